[hdl/spi_pkg.sv]
// ----------------------------------------------------------------------------
// spi_pkg
// Shared widths, codes and types for the stepper position indexer.
// ----------------------------------------------------------------------------
package spi_pkg;

  localparam int POSITION_BITS = 16;
  localparam int PERIOD_BITS   = 24;
  localparam int MODE_BITS     = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  localparam logic [POSITION_BITS-1:0] STEP_LIMIT_RST      = POSITION_BITS'(65535);
  localparam logic [PERIOD_BITS-1:0]   HOMING_INTERVAL_RST = PERIOD_BITS'(5000);

  typedef enum logic [MODE_BITS-1:0] {
    MODE_TICK = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_HOME = 2'd2,
    MODE_RSVD = 2'd3
  } spi_mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_STEP_LIMIT      = 2'd0,
    CFG_HOMING_INTERVAL = 2'd1
  } spi_cfg_idx_t;

  // Motion state carried from item to item
  typedef struct packed {
    logic [POSITION_BITS-1:0] position;
    logic [POSITION_BITS-1:0] target;
    logic [PERIOD_BITS-1:0]   period;
    logic [PERIOD_BITS-1:0]   wait_count;
    logic                     moving;
    logic                     homing;
    logic                     home_done;
    logic                     dir_level;
  } spi_state_t;

  // Configuration register contents
  typedef struct packed {
    logic [POSITION_BITS-1:0] step_limit;
    logic [PERIOD_BITS-1:0]   homing_interval;
  } spi_cfg_t;

  // Result of one request
  typedef struct packed {
    logic                     step_pulse;
    logic                     direction;
    logic [POSITION_BITS-1:0] current_position;
    logic                     move_done;
    logic                     calibrated;
  } spi_result_t;

endpackage

[hdl/spi_cfg_regs.sv]
// ----------------------------------------------------------------------------
// spi_cfg_regs
// Configuration registers: move limit and homing step interval.
// ----------------------------------------------------------------------------
module spi_cfg_regs
  import spi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [CFG_IDX_BITS-1:0]  wr_index,
  input  logic [CFG_DATA_BITS-1:0] wr_data,
  output spi_cfg_t                 cfg
);

  spi_cfg_t cfg_r;
  spi_cfg_t cfg_nxt;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (spi_cfg_idx_t'(wr_index))
        CFG_STEP_LIMIT:      cfg_nxt.step_limit = wr_data[POSITION_BITS-1:0];
        CFG_HOMING_INTERVAL: cfg_nxt.homing_interval = wr_data[PERIOD_BITS-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_limit      <= STEP_LIMIT_RST;
      cfg_r.homing_interval <= HOMING_INTERVAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/spi_step_logic.sv]
// ----------------------------------------------------------------------------
// spi_step_logic
// Next-state and result logic for one request: move, homing or tick.
// ----------------------------------------------------------------------------
module spi_step_logic
  import spi_pkg::*;
(
  input  spi_state_t               state,
  input  spi_cfg_t                 cfg,
  input  logic [MODE_BITS-1:0]     mode,
  input  logic [POSITION_BITS-1:0] target_position,
  input  logic [PERIOD_BITS-1:0]   step_period,
  input  logic                     home_switch,
  output spi_state_t               state_nxt,
  output spi_result_t              result
);

  logic pulse;
  logic move_ok;

  // A move step is legal only toward an in-range target with a nonzero period
  assign move_ok = (state.target != state.position) &&
                   (state.period != '0) &&
                   (state.target != '0) &&
                   (state.target < cfg.step_limit);

  always_comb begin
    state_nxt = state;
    pulse     = 1'b0;
    unique case (spi_mode_t'(mode))
      MODE_MOVE: begin
        // Ignore move commands while homing
        if (!state.homing) begin
          state_nxt.target     = target_position;
          state_nxt.period     = step_period;
          state_nxt.moving     = 1'b1;
          state_nxt.wait_count = '0;
        end
      end
      MODE_HOME: begin
        // Abort any move and restart homing
        state_nxt.moving     = 1'b0;
        state_nxt.homing     = 1'b1;
        state_nxt.home_done  = 1'b0;
        state_nxt.wait_count = '0;
      end
      MODE_TICK: begin
        if (state.homing) begin
          if (state.wait_count != '0) begin
            state_nxt.wait_count = state.wait_count - 1'b1;
          end else if (home_switch) begin
            // Step backward, then wait one interval (zero acts as one)
            pulse               = 1'b1;
            state_nxt.dir_level = 1'b1;
            state_nxt.wait_count = (cfg.homing_interval == '0) ? '0 :
                                   cfg.homing_interval - 1'b1;
          end else begin
            // Home reached: zero the position
            state_nxt.homing    = 1'b0;
            state_nxt.home_done = 1'b1;
            state_nxt.position  = '0;
            state_nxt.dir_level = 1'b0;
          end
        end else if (state.moving) begin
          if (state.wait_count != '0) begin
            state_nxt.wait_count = state.wait_count - 1'b1;
          end else if (move_ok) begin
            pulse = 1'b1;
            if (state.target > state.position) begin
              state_nxt.dir_level = 1'b0;
              state_nxt.position  = state.position + 1'b1;
            end else begin
              state_nxt.dir_level = 1'b1;
              state_nxt.position  = state.position - 1'b1;
            end
            state_nxt.wait_count = state.period - 1'b1;
          end else begin
            state_nxt.moving = 1'b0;
          end
        end
      end
      MODE_RSVD: begin
        state_nxt = state;
      end
      default: begin
        state_nxt = state;
      end
    endcase
  end

  // Report status after this request
  always_comb begin
    result.step_pulse       = pulse;
    result.direction        = state_nxt.dir_level;
    result.current_position = state_nxt.position;
    result.move_done        = ~state_nxt.moving;
    result.calibrated       = state_nxt.home_done;
  end

endmodule

[hdl/stepper_position_indexer_core.sv]
// An accepted request's result is registered and shows on the out_ port the cycle after.
// Throughput: one request per cycle; the output register drains and refills
// in the same cycle, so in_ready drops only while a result is held by out_ready.
// Reset (rst_n low, synchronous) zeroes the motion state, empties the output
// register and loads a step limit of 65535 and a homing interval of 5000.
// ----------------------------------------------------------------------------
// stepper_position_indexer_core
// Step/direction indexer with homing, one request per 1 us tick.
// ----------------------------------------------------------------------------
module stepper_position_indexer_core
  import spi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // Configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  // Request channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [MODE_BITS-1:0]     in_mode,
  input  logic [POSITION_BITS-1:0] in_target_position,
  input  logic [PERIOD_BITS-1:0]   in_step_period,
  input  logic                     in_home_switch,
  // Result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_step_pulse,
  output logic                     out_direction,
  output logic [POSITION_BITS-1:0] out_current_position,
  output logic                     out_move_done,
  output logic                     out_calibrated
);

  spi_cfg_t    cfg;
  spi_state_t  state_r;
  spi_state_t  state_nxt;
  spi_result_t result;
  spi_result_t result_r;
  logic        out_valid_r;
  logic        in_fire;

  assign cfg_ready = 1'b1;

  spi_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  spi_step_logic u_step (
    .state           (state_r),
    .cfg             (cfg),
    .mode            (in_mode),
    .target_position (in_target_position),
    .step_period     (in_step_period),
    .home_switch     (in_home_switch),
    .state_nxt       (state_nxt),
    .result          (result)
  );

  // Accept while the output register is empty or being drained
  assign in_ready = ~out_valid_r | out_ready;
  assign in_fire  = in_valid & in_ready;

  // Advance motion state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_step_pulse       = result_r.step_pulse;
  assign out_direction        = result_r.direction;
  assign out_current_position = result_r.current_position;
  assign out_move_done        = result_r.move_done;
  assign out_calibrated       = result_r.calibrated;

endmodule

[hdl/spi_checker.sv]
// ----------------------------------------------------------------------------
// spi_checker
// Port-level checks for the stepper position indexer, bound to the top level.
// ----------------------------------------------------------------------------
module spi_checker
  import spi_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     out_step_pulse,
  input logic                     out_direction,
  input logic [POSITION_BITS-1:0] out_current_position,
  input logic                     out_move_done,
  input logic                     out_calibrated
);

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_current_position) &&
    $stable(out_step_pulse) && $stable(out_direction) &&
    $stable(out_move_done) && $stable(out_calibrated))
    else $error("stalled result changed");

  // Every accepted request yields a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  // Backpressure: no request taken while a result is stuck
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request accepted over a held result");

  // An upward step only happens during a move
  a_up_step_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_step_pulse && !out_direction |-> !out_move_done)
    else $error("upward step reported with no move active");

endmodule

bind stepper_position_indexer_core spi_checker u_spi_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_step_pulse       (out_step_pulse),
  .out_direction        (out_direction),
  .out_current_position (out_current_position),
  .out_move_done        (out_move_done),
  .out_calibrated       (out_calibrated)
);
